// ----- hw/rtl/kmd_pkg.sv -----
package kmd_pkg;

  // Matrix geometry. Key index is row * COLUMN_COUNT + column.
  localparam int ROW_COUNT    = 3;
  localparam int COLUMN_COUNT = 3;
  localparam int KEY_TOTAL    = ROW_COUNT * COLUMN_COUNT;
  localparam int KEY_W        = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;

  localparam int CNT_W       = 4;
  localparam int USAGE_BASE  = 4;
  localparam int REPORT_HDR  = 2;
  localparam int BOOT_LEN    = 8;
  localparam int BITMAP_LEN  = 34;
  localparam int BYTE_IDX_W  = 6;
  localparam int BYTE_W      = 8;
  localparam int RPT_ID_W    = 2;
  localparam int CODE_W      = BYTE_IDX_W + 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 4'd3;
  localparam logic             MODE_RESET     = 1'b1;

  typedef enum logic [RPT_ID_W-1:0] {
    RPT_NONE   = 2'd0,
    RPT_BOOT   = 2'd1,
    RPT_BITMAP = 2'd2
  } report_id_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_COUNT = 1'b0,
    REG_PROTOCOL_MODE  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_byte;
  } dp_status_t;

endpackage

// ----- hw/rtl/kmd_in_if.sv -----
interface kmd_in_if;
  logic                          valid;
  logic                          ready;
  logic [kmd_pkg::KEY_TOTAL-1:0] raw_keys;
  logic                          host_ready;

  modport source (output valid, output raw_keys, output host_ready, input ready);
  modport sink   (input valid, input raw_keys, input host_ready, output ready);
endinterface

// ----- hw/rtl/kmd_out_if.sv -----
interface kmd_out_if;
  logic                            valid;
  logic                            ready;
  logic [kmd_pkg::KEY_TOTAL-1:0]   key_state;
  logic [kmd_pkg::RPT_ID_W-1:0]    report_id;
  logic [kmd_pkg::BYTE_IDX_W-1:0]  byte_index;
  logic [kmd_pkg::BYTE_W-1:0]      byte_value;
  logic                            last;

  modport source (output valid, output key_state, output report_id, output byte_index,
                  output byte_value, output last, input ready);
  modport sink   (input valid, input key_state, input report_id, input byte_index,
                  input byte_value, input last, output ready);
endinterface

// ----- hw/rtl/kmd_cfg_if.sv -----
interface kmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kmd_pkg::CFG_IDX_W-1:0]   index;
  logic [kmd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/kmd_ctrl.sv -----
module kmd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmd_pkg::dp_status_t status,
  output kmd_pkg::dp_cmd_t    cmd
);
  import kmd_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Idle takes one scan; emit hands one byte a cycle to the output register while it is free.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.load = status.out_free;
        if (status.out_free && status.last_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/kmd_datapath.sv -----
module kmd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kmd_pkg::dp_cmd_t                  cmd,
  output kmd_pkg::dp_status_t               status,
  input  logic [kmd_pkg::KEY_TOTAL-1:0]     raw_keys,
  input  logic                              host_ready,
  input  logic                              cfg_valid,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [kmd_pkg::KEY_TOTAL-1:0]     out_key_state,
  output logic [kmd_pkg::RPT_ID_W-1:0]      out_report_id,
  output logic [kmd_pkg::BYTE_IDX_W-1:0]    out_byte_index,
  output logic [kmd_pkg::BYTE_W-1:0]        out_byte_value,
  output logic                              out_last
);
  import kmd_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] debounce_count_r;
  logic             protocol_mode_r;

  // Debounce state.
  logic [KEY_TOTAL-1:0] stable_r, stable_nxt;
  logic [CNT_W-1:0]     cnt_r   [KEY_TOTAL];
  logic [CNT_W-1:0]     cnt_nxt [KEY_TOTAL];
  logic [CNT_W-1:0]     cnt_inc [KEY_TOTAL];
  logic [KEY_TOTAL-1:0] flip;

  // Report sequencing.
  report_id_t           kind_r;
  report_id_t           kind_nxt;
  logic [BYTE_IDX_W-1:0] byte_cnt_r;
  logic [BYTE_IDX_W-1:0] last_idx;
  logic [KEY_TOTAL-1:0] pend_r;
  logic [KEY_TOTAL-1:0] pend_low;
  logic [KEY_W-1:0]     pend_idx;

  logic [BYTE_W-1:0]     byte_val;
  logic [BYTE_IDX_W-1:0] bmp_pos;
  logic [CODE_W-1:0]     bmp_code [8];
  logic [CODE_W-1:0]     bmp_key  [8];

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_count_r <= DEBOUNCE_RESET;
      protocol_mode_r  <= MODE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_COUNT: debounce_count_r <= cfg_data;
        REG_PROTOCOL_MODE:  protocol_mode_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // One independent lane per key.
  always_comb begin
    for (int i = 0; i < KEY_TOTAL; i++) begin
      cnt_inc[i]    = cnt_r[i] + 1'b1;
      flip[i]       = 1'b0;
      stable_nxt[i] = stable_r[i];
      if (raw_keys[i] == stable_r[i]) begin
        cnt_nxt[i] = '0;
      end else if (cnt_inc[i] >= debounce_count_r) begin
        cnt_nxt[i]    = '0;
        stable_nxt[i] = raw_keys[i];
        flip[i]       = 1'b1;
      end else begin
        cnt_nxt[i] = cnt_inc[i];
      end
    end
  end

  always_comb begin
    if (|flip && host_ready) begin
      kind_nxt = protocol_mode_r ? RPT_BITMAP : RPT_BOOT;
    end else begin
      kind_nxt = RPT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      for (int i = 0; i < KEY_TOTAL; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.accept) begin
      stable_r <= stable_nxt;
      for (int i = 0; i < KEY_TOTAL; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // Boot slots drain the pressed set lowest key first.
  assign pend_low = pend_r & (~pend_r + 1'b1);

  always_comb begin
    pend_idx = '0;
    for (int k = 0; k < KEY_TOTAL; k++) begin
      if (pend_low[k]) begin
        pend_idx = pend_idx | KEY_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= RPT_NONE;
      byte_cnt_r <= '0;
      pend_r     <= '0;
    end else if (cmd.accept) begin
      kind_r     <= kind_nxt;
      byte_cnt_r <= '0;
      pend_r     <= stable_nxt;
    end else if (cmd.load) begin
      byte_cnt_r <= byte_cnt_r + 1'b1;
      if (kind_r == RPT_BOOT && byte_cnt_r >= BYTE_IDX_W'(REPORT_HDR)) begin
        pend_r <= pend_r & ~pend_low;
      end
    end
  end

  always_comb begin
    unique case (kind_r)
      RPT_BOOT:   last_idx = BYTE_IDX_W'(BOOT_LEN - 1);
      RPT_BITMAP: last_idx = BYTE_IDX_W'(BITMAP_LEN - 1);
      default:    last_idx = '0;
    endcase
  end

  // Bitmap byte p holds the usage codes 8p..8p+7, one bit each.
  assign bmp_pos = byte_cnt_r - BYTE_IDX_W'(REPORT_HDR);

  always_comb begin
    byte_val = '0;
    for (int b = 0; b < 8; b++) begin
      bmp_code[b] = {bmp_pos, 3'(b)};
      bmp_key[b]  = bmp_code[b] - CODE_W'(USAGE_BASE);
    end
    unique case (kind_r)
      RPT_BOOT: begin
        if (byte_cnt_r >= BYTE_IDX_W'(REPORT_HDR) && pend_r != '0) begin
          byte_val = BYTE_W'(USAGE_BASE) + BYTE_W'(pend_idx);
        end
      end
      RPT_BITMAP: begin
        if (byte_cnt_r >= BYTE_IDX_W'(REPORT_HDR)) begin
          for (int b = 0; b < 8; b++) begin
            if (bmp_code[b] >= CODE_W'(USAGE_BASE) && bmp_key[b] < CODE_W'(KEY_TOTAL)) begin
              byte_val[b] = stable_r[bmp_key[b][KEY_W-1:0]];
            end
          end
        end
      end
      default: begin
        byte_val = '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_key_state  <= stable_r;
      out_report_id  <= kind_r;
      out_byte_index <= byte_cnt_r;
      out_byte_value <= byte_val;
      out_last       <= (byte_cnt_r == last_idx);
    end
  end

  assign out_valid        = out_valid_r;
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.last_byte = (byte_cnt_r == last_idx);

endmodule

// ----- hw/rtl/key_matrix_debounce_hid_report_top.sv -----
// An item is taken in the idle state; its first result byte is then loaded into the output
// register from the emit state, and further report bytes follow one per cycle while the sink is ready.
// A new item is taken only after all result bytes of the last one are loaded: 1 (no report),
// 8 (boot) or 34 (bitmap), one report byte per cycle while the output register is free.
// Reset (rst_n, synchronous, active low): keys released, counters zero, debounce count 3,
// bitmap protocol mode, output empty.
module key_matrix_debounce_hid_report_top (
  input logic       clk,
  input logic       rst_n,
  kmd_in_if.sink    in_ch,
  kmd_out_if.source out_ch,
  kmd_cfg_if.sink   cfg_ch
);
  import kmd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Config writes are always taken; the user must write only while the block is idle; not enforced.
  assign cfg_ch.ready = 1'b1;

  // The controller sequences one scan at a time: it takes an item in the idle state,
  // then stays in the emit state until every result byte of that scan is loaded.
  kmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the debounce lanes, the configuration registers, the report
  // byte generator and the output register that decouples the result sink.
  kmd_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .raw_keys       (in_ch.raw_keys),
    .host_ready     (in_ch.host_ready),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_key_state  (out_ch.key_state),
    .out_report_id  (out_ch.report_id),
    .out_byte_index (out_ch.byte_index),
    .out_byte_value (out_ch.byte_value),
    .out_last       (out_ch.last)
  );

`ifndef SYNTHESIS
  // A taken scan blocks the input until its report bytes are loaded.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted again right after a scan");

  // A scan without a report gives exactly one empty, final result.
  a_none_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.report_id == RPT_NONE |->
      out_ch.last && out_ch.byte_value == '0 && out_ch.byte_index == '0)
    else $error("empty result is not a single final item");

  // The final byte of a bitmap report sits at the report's end.
  a_bitmap_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.report_id == RPT_BITMAP && out_ch.last |->
      out_ch.byte_index == BYTE_IDX_W'(BITMAP_LEN - 1))
    else $error("bitmap report ended at the wrong byte");

  // The final byte of a boot report sits at the report's end.
  a_boot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.report_id == RPT_BOOT && out_ch.last |->
      out_ch.byte_index == BYTE_IDX_W'(BOOT_LEN - 1))
    else $error("boot report ended at the wrong byte");
`endif

endmodule

// ----- dv/tb.sv -----
module tb;
  import kmd_pkg::*;

  // Six usage-code slots follow the two header bytes of a boot report.
  localparam int BOOT_SLOTS    = BOOT_LEN - REPORT_HDR;
  // Idle cycles allowed after the last result before the block is treated as idle.
  localparam int SETTLE_CYCLES = 4;
  // Time limit for the whole run, well above what the slowest correct run needs.
  localparam int RUN_LIMIT     = 600000;

  // One expected result item: a report byte, or the single item of a quiet scan.
  typedef struct packed {
    logic [KEY_TOTAL-1:0]  keys;
    report_id_t            id;
    logic [BYTE_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]     val;
    logic                  last;
  } hid_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  kmd_in_if  in_ch();
  kmd_out_if out_ch();
  kmd_cfg_if cfg_ch();

  key_matrix_debounce_hid_report_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: debounced keys, per-key bounce counters and the two registers.
  logic [KEY_TOTAL-1:0] debounced_keys = '0;
  logic [CNT_W-1:0]     bounce_cnt [KEY_TOTAL];
  logic [CNT_W-1:0]     debounce_limit = DEBOUNCE_RESET;
  logic                 bitmap_mode    = MODE_RESET;

  hid_byte_t pending_bytes [$];

  // When calm is set, neither side inserts idle cycles any more.
  bit calm = 1'b0;
  int mismatch_count = 0;
  int scans_sent     = 0;
  int results_seen   = 0;
  int boot_reports   = 0;
  int bitmap_reports = 0;
  int quiet_scans    = 0;
  int settings_used  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the debounce state for one scan and queue every result item it should cause.
  function automatic void predict_scan(input logic [KEY_TOTAL-1:0] raw, input logic host);
    logic             flipped;
    logic [CNT_W-1:0] bumped;
    logic [7:0]       rpt [BITMAP_LEN];
    int               slot;
    int               code;
    int               len;
    report_id_t       id;
    flipped = 1'b0;
    for (int k = 0; k < KEY_TOTAL; k++) begin
      if (raw[k] == debounced_keys[k]) begin
        bounce_cnt[k] = '0;
      end else begin
        // The counter wraps at four bits; a limit of zero lets the first differing scan flip.
        bumped = bounce_cnt[k] + 1'b1;
        if (bumped >= debounce_limit) begin
          bounce_cnt[k]     = '0;
          debounced_keys[k] = raw[k];
          flipped           = 1'b1;
        end else begin
          bounce_cnt[k] = bumped;
        end
      end
    end

    if (!(flipped && host)) begin
      // A change seen while the host is busy is simply lost; no report follows later.
      pending_bytes.push_back('{debounced_keys, RPT_NONE, '0, '0, 1'b1});
    end else begin
      foreach (rpt[j]) rpt[j] = '0;
      if (!bitmap_mode) begin
        // Boot report: codes in key order, keys past the sixth are dropped.
        slot = 0;
        for (int k = 0; k < KEY_TOTAL; k++) begin
          if (debounced_keys[k] && slot < BOOT_SLOTS) begin
            rpt[REPORT_HDR + slot] = 8'(USAGE_BASE + k);
            slot++;
          end
        end
        len = BOOT_LEN;
        id  = RPT_BOOT;
      end else begin
        for (int k = 0; k < KEY_TOTAL; k++) begin
          if (debounced_keys[k]) begin
            code = USAGE_BASE + k;
            rpt[REPORT_HDR + (code >> 3)][code & 7] = 1'b1;
          end
        end
        len = BITMAP_LEN;
        id  = RPT_BITMAP;
      end
      for (int n = 0; n < len; n++) begin
        pending_bytes.push_back('{debounced_keys, id, n[BYTE_IDX_W-1:0], rpt[n], n == len - 1});
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [KEY_TOTAL-1:0] want,
                                      input logic [KEY_TOTAL-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Each accepted result item is compared with the oldest expected one.
  always @(posedge clk) begin : check_results
    hid_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result item, key_state 0x%0h report_id %0d byte %0d",
                 $time, out_ch.key_state, out_ch.report_id, out_ch.byte_index);
        mismatch_count++;
      end else begin
        want = pending_bytes.pop_front();
        check_field("key_state", want.keys, out_ch.key_state);
        check_field("report_id", want.id, out_ch.report_id);
        check_field("byte_index", want.idx, out_ch.byte_index);
        check_field("byte_value", want.val, out_ch.byte_value);
        check_field("last", want.last, out_ch.last);
        if (want.last) begin
          case (want.id)
            RPT_BOOT:   boot_reports++;
            RPT_BITMAP: bitmap_reports++;
            default:    quiet_scans++;
          endcase
        end
      end
    end
  end

  // The result sink stalls in random bursts between runs of readiness.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one scan. Before it the sender may idle for a short burst, or now and then hold
  // off until every outstanding result has come back. Valid is left high on return so
  // that back-to-back scans never lower and raise it within one step.
  task automatic send_scan(input logic [KEY_TOTAL-1:0] raw, input logic host);
    if (!calm && $urandom_range(0, 39) == 0) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (pending_bytes.size() != 0);
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_keys   <= raw;
    in_ch.host_ready <= host;
    do @(posedge clk); while (!in_ch.ready);
    predict_scan(raw, host);
    scans_sent++;
  endtask

  // Stop sending and wait until every expected item has arrived and the block is idle.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_DEBOUNCE_COUNT) begin
      debounce_limit = value;
    end else begin
      bitmap_mode = value[0];
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CNT_W-1:0] count, input logic mode);
    quiesce();
    write_reg(REG_DEBOUNCE_COUNT, count);
    write_reg(REG_PROTOCOL_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    settings_used++;
  endtask

  // Reset settings: a key needs three scans to register, and reports are bitmaps.
  // Key A alone, then every key at once, which also reaches into the second bitmap byte.
  task automatic test_default_bitmap();
    repeat (3) send_scan(9'h001, 1'b1);
    repeat (3) send_scan(9'h1FF, 1'b1);
  endtask

  // With a count of one, a release seen while the host is busy gives no report, and
  // the same keys with the host ready give none either, since nothing changes then.
  task automatic test_host_busy();
    apply_setting(4'd1, 1'b1);
    send_scan(9'h000, 1'b0);
    send_scan(9'h000, 1'b1);
    send_scan(9'h100, 1'b1);
  endtask

  // Boot reports hold at most six codes; the seventh and later keys are dropped.
  task automatic test_boot_overflow();
    apply_setting(4'd1, 1'b0);
    send_scan(9'h1FF, 1'b1);
    send_scan(9'h0FE, 1'b1);
    send_scan(9'h000, 1'b1);
  endtask

  // A count of zero acts like a count of one.
  task automatic test_zero_count();
    apply_setting(4'd0, 1'b0);
    send_scan(9'h155, 1'b1);
    send_scan(9'h0AA, 1'b1);
    send_scan(9'h0AA, 1'b1);
  endtask

  // A bounce shorter than the count clears that key's counter and does not flip the key.
  task automatic test_short_bounce();
    apply_setting(4'd3, 1'b1);
    repeat (2) send_scan(9'h003, 1'b1);
    send_scan(9'h000, 1'b1);
    repeat (2) send_scan(9'h003, 1'b1);
  endtask

  // Random traffic under the current setting. Most of it holds a new key pattern long
  // enough to settle, so reports really occur; the rest is raw noise and bounces that
  // end too early.
  task automatic run_traffic(input int budget);
    int unsigned          kind;
    int                   hold;
    int                   need;
    int                   stop_at;
    logic [KEY_TOTAL-1:0] pattern;
    stop_at = scans_sent + budget;
    need    = (debounce_limit == 0) ? 1 : int'(debounce_limit);
    while (scans_sent < stop_at) begin
      kind    = $urandom_range(0, 9);
      pattern = KEY_TOTAL'($urandom_range(0, (1 << KEY_TOTAL) - 1));
      if (kind < 7) begin
        hold = need + $urandom_range(0, 2);
        repeat (hold) send_scan(pattern, $urandom_range(0, 4) != 0);
      end else if (kind < 9) begin
        send_scan(pattern, 1'($urandom_range(0, 1)));
      end else begin
        hold = (need > 1) ? $urandom_range(1, need - 1) : 1;
        repeat (hold) send_scan(pattern, 1'b1);
        send_scan(debounced_keys, 1'b1);
      end
    end
  endtask

  task automatic test_random_settings();
    apply_setting(4'd2, 1'b0);
    run_traffic(44);
    apply_setting(4'd15, 1'b1);
    run_traffic(44);
    apply_setting(4'd1, 1'b0);
    run_traffic(44);
    apply_setting(4'd7, 1'b1);
    run_traffic(44);
    apply_setting(4'd0, 1'b0);
    run_traffic(44);
  endtask

  // The last stretch runs with both sides always ready.
  task automatic test_full_rate();
    apply_setting(4'd1, 1'b1);
    calm = 1'b1;
    run_traffic(44);
  endtask

  initial begin
    foreach (bounce_cnt[k]) bounce_cnt[k] = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.raw_keys   <= '0;
    in_ch.host_ready <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_DEBOUNCE_COUNT;
    cfg_ch.data      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_bitmap();
    test_host_busy();
    test_boot_overflow();
    test_zero_count();
    test_short_bounce();
    test_random_settings();
    test_full_rate();

    // Drain, then leave room for any stray item the block might still produce.
    quiesce();
    repeat (40) @(posedge clk);

    $display("Covered %0d scans under %0d register settings; %0d result items checked.",
             scans_sent, settings_used + 1, results_seen);
    $display("Seen %0d boot reports, %0d bitmap reports and %0d scans without a report.",
             boot_reports, bitmap_reports, quiet_scans);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog in case a handshake never completes.
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d result items still expected.", pending_bytes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
